>>> hdl/bgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bayer BGGR bilinear demosaic: shared definitions
// Payload structures, register indexes and reset values used by the RTL and
// by the port checker.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 9;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 10'd316;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 10'd208;
    localparam logic [CFG_W-1:0] DIM_MIN          = 10'd4;

    typedef struct packed {
        logic [PIX_W-1:0] raw_pixel;
        logic             frame_start;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic               run_last;
    } out_t;

endpackage
`default_nettype wire

>>> hdl/bgd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module bgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hdl/bayer_bggr_bilinear_demosaic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bayer BGGR bilinear demosaic, top level
// Streams raw BGGR samples in raster order and returns RGB pixels with their
// coordinates; border pixels are copies of the adjacent interior pixel.
// ----------------------------------------------------------------------------
// The block takes one raw sample per clock and gives one RGB result per clock
// for each interior pixel while m_ready is high. A pixel next to a border is
// followed by one or three copies for the border positions, one per clock from
// the output register while m_ready is high, and the input can stall meanwhile.
// A result passes from the sample that completes its neighborhood through the
// line-store read, the window and the output register, in that order. The
// two previous rows sit in a single RAM of MAX_WIDTH entries that is read and
// written back once per sample. No clearing pass is run after reset.
module bayer_bggr_bilinear_demosaic
    import bgd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = CW + 1;
    localparam int HEW = RW + 1;
    localparam int XW  = (WEW > CFG_W) ? WEW : CFG_W;
    localparam int YW  = (HEW > CFG_W) ? HEW : CFG_W;

    typedef struct packed {
        logic               emit;
        logic               hx;
        logic               vy;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
    } meta_t;

    typedef enum logic [3:0] {
        PH_INT = 4'b0001,
        PH_HOR = 4'b0010,
        PH_VER = 4'b0100,
        PH_COR = 4'b1000
    } phase_t;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [WEW-1:0]   w_eff;
    logic [HEW-1:0]   h_eff;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [WEW-1:0] c_start, c_inc;
    logic [HEW-1:0] r_start, r_inc;
    logic [CW-1:0]  acc_c, acc_cx;
    logic [RW-1:0]  acc_r, acc_cy;
    meta_t          acc_meta;

    logic             s1_valid_reg;
    meta_t            s1_meta_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic             s1_fwd_reg;
    logic [PIX_W-1:0] fwd_older_reg;
    logic [PIX_W-1:0] fwd_newer_reg;

    logic  s2_valid_reg;
    meta_t s2_meta_reg;

    logic [PIX_W-1:0] win_reg [3][3];

    logic             o_valid_reg;
    phase_t           o_phase_reg;
    meta_t            o_meta_reg;
    logic [PIX_W-1:0] o_red_reg, o_green_reg, o_blue_reg;
    logic             o_last;
    phase_t           o_phase_step;

    logic out_free, adv1, adv2, acc, s1_move, load_out;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0]   older_eff, newer_eff;

    logic [PIX_W:0]   horiz, vert;
    logic [PIX_W+1:0] diag, hv;
    logic [PIX_W-1:0] red_c, green_c, blue_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (XW'(frame_width_reg) < XW'(DIM_MIN)) begin
            w_eff = WEW'(DIM_MIN);
        end else if (XW'(frame_width_reg) > XW'(MAX_WIDTH)) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = WEW'(frame_width_reg);
        end
        if (YW'(frame_height_reg) < YW'(DIM_MIN)) begin
            h_eff = HEW'(DIM_MIN);
        end else if (YW'(frame_height_reg) > YW'(MAX_HEIGHT)) begin
            h_eff = HEW'(MAX_HEIGHT);
        end else begin
            h_eff = HEW'(frame_height_reg);
        end
    end

    assign out_free = !o_valid_reg || (o_last && m_ready);
    assign adv2     = !s2_valid_reg || !s2_meta_reg.emit || out_free;
    assign adv1     = !s1_valid_reg || adv2;
    assign s_ready  = adv1;
    assign acc      = s_valid && adv1;
    assign s1_move  = s1_valid_reg && adv2;
    assign load_out = s2_valid_reg && s2_meta_reg.emit && out_free;

    always_comb begin
        c_start = s_data.frame_start ? '0 : WEW'(col_reg);
        r_start = s_data.frame_start ? '0 : HEW'(row_reg);
        if (c_start >= w_eff) begin
            c_start = '0;
            r_start = r_start + HEW'(1);
        end
        if (r_start >= h_eff) begin
            r_start = '0;
        end
        acc_c = c_start[CW-1:0];
        acc_r = r_start[RW-1:0];
        c_inc = WEW'(acc_c) + WEW'(1);
        r_inc = HEW'(acc_r) + HEW'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (c_inc >= w_eff) begin
                col_next = '0;
                row_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
            end else begin
                col_next = c_inc[CW-1:0];
                row_next = acc_r;
            end
        end

        acc_cx        = acc_c - CW'(1);
        acc_cy        = acc_r - RW'(1);
        acc_meta.emit = (acc_c > CW'(1)) && (acc_r > RW'(1));
        acc_meta.cx   = COORD_W'(acc_cx);
        acc_meta.cy   = COORD_W'(acc_cy);
        acc_meta.hx   = 1'b0;
        acc_meta.bx   = '0;
        acc_meta.vy   = 1'b0;
        acc_meta.by   = '0;
        if (acc_cx == CW'(1)) begin
            acc_meta.hx = 1'b1;
        end else if (WEW'(acc_cx) == w_eff - WEW'(2)) begin
            acc_meta.hx = 1'b1;
            acc_meta.bx = COORD_W'(w_eff - WEW'(1));
        end
        if (acc_cy == RW'(1)) begin
            acc_meta.vy = 1'b1;
        end else if (HEW'(acc_cy) == h_eff - HEW'(2)) begin
            acc_meta.vy = 1'b1;
            acc_meta.by = COORD_W'(h_eff - HEW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    bgd_ram #(
        .WIDTH(2 * PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk  (aclk),
        .we   (s1_move),
        .waddr(s1_addr_reg),
        .wdata({newer_eff, s1_px_reg}),
        .re   (acc),
        .raddr(acc_c),
        .rdata(ram_rdata)
    );

    assign older_eff = s1_fwd_reg ? fwd_older_reg : ram_rdata[2*PIX_W-1:PIX_W];
    assign newer_eff = s1_fwd_reg ? fwd_newer_reg : ram_rdata[PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv1) begin
            s1_valid_reg <= s_valid;
        end
        if (acc) begin
            s1_meta_reg   <= acc_meta;
            s1_px_reg     <= s_data.raw_pixel;
            s1_addr_reg   <= acc_c;
            s1_fwd_reg    <= s1_move && (s1_addr_reg == acc_c);
            fwd_older_reg <= newer_eff;
            fwd_newer_reg <= s1_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv2) begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (s1_move) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= older_eff;
            win_reg[1][2] <= newer_eff;
            win_reg[2][2] <= s1_px_reg;
        end
    end

    always_comb begin
        horiz = {1'b0, win_reg[1][0]} + {1'b0, win_reg[1][2]};
        vert  = {1'b0, win_reg[0][1]} + {1'b0, win_reg[2][1]};
        diag  = {2'b00, win_reg[0][0]} + {2'b00, win_reg[0][2]}
              + {2'b00, win_reg[2][0]} + {2'b00, win_reg[2][2]};
        hv    = {1'b0, horiz} + {1'b0, vert};
        case ({s2_meta_reg.cy[0], s2_meta_reg.cx[0]})
            2'b11: begin
                red_c   = win_reg[1][1];
                green_c = hv[PIX_W+1:2];
                blue_c  = diag[PIX_W+1:2];
            end
            2'b10: begin
                red_c   = horiz[PIX_W:1];
                green_c = win_reg[1][1];
                blue_c  = vert[PIX_W:1];
            end
            2'b01: begin
                red_c   = vert[PIX_W:1];
                green_c = win_reg[1][1];
                blue_c  = horiz[PIX_W:1];
            end
            default: begin
                red_c   = diag[PIX_W+1:2];
                green_c = hv[PIX_W+1:2];
                blue_c  = win_reg[1][1];
            end
        endcase
    end

    always_comb begin
        case (o_phase_reg)
            PH_INT: begin
                o_last       = !(o_meta_reg.hx || o_meta_reg.vy);
                o_phase_step = o_meta_reg.hx ? PH_HOR : PH_VER;
            end
            PH_HOR: begin
                o_last       = !o_meta_reg.vy;
                o_phase_step = PH_VER;
            end
            PH_VER: begin
                o_last       = !(o_meta_reg.hx && o_meta_reg.vy);
                o_phase_step = PH_COR;
            end
            default: begin
                o_last       = 1'b1;
                o_phase_step = PH_INT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            o_phase_reg <= PH_INT;
        end else if (load_out) begin
            o_valid_reg <= 1'b1;
            o_phase_reg <= PH_INT;
        end else if (o_valid_reg && m_ready) begin
            if (o_last) begin
                o_valid_reg <= 1'b0;
            end else begin
                o_phase_reg <= o_phase_step;
            end
        end
        if (load_out) begin
            o_meta_reg  <= s2_meta_reg;
            o_red_reg   <= red_c;
            o_green_reg <= green_c;
            o_blue_reg  <= blue_c;
        end
    end

    assign m_valid         = o_valid_reg;
    assign m_data.out_col  = (o_phase_reg == PH_HOR || o_phase_reg == PH_COR)
                           ? o_meta_reg.bx : o_meta_reg.cx;
    assign m_data.out_row  = (o_phase_reg == PH_VER || o_phase_reg == PH_COR)
                           ? o_meta_reg.by : o_meta_reg.cy;
    assign m_data.red      = o_red_reg;
    assign m_data.green    = o_green_reg;
    assign m_data.blue     = o_blue_reg;
    assign m_data.run_last = o_last;

endmodule
`default_nettype wire

>>> hdl/bgd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bayer BGGR bilinear demosaic: port checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bgd_checker
    import bgd_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Result request dropped before it was taken.");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("Result payload changed while stalled.");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |=> m_valid)
        else $error("Border copy missing after a result that was not last.");

    a_copy_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |=>
            m_data.red == $past(m_data.red) && m_data.green == $past(m_data.green)
            && m_data.blue == $past(m_data.blue))
        else $error("Border copy differs in color from its interior pixel.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result request present right after reset.");

endmodule

bind bayer_bggr_bilinear_demosaic bgd_checker u_bgd_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
`default_nettype wire
